// ===== hw/rtl/xrr_pkg.sv =====
// Shared types and constants for the ranged xorshift random generator.
`timescale 1ns / 1ps

package xrr_pkg;

    // Field widths.
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned STATE_W = 64;

    // Built-in seed, used after reset and whenever a zero seed is written.
    localparam logic [STATE_W-1:0] SEED_DEFAULT = 64'd88172645463325252;

    // Xorshift shift distances.
    localparam int unsigned SHIFT_A = 13;
    localparam int unsigned SHIFT_B = 7;
    localparam int unsigned SHIFT_C = 17;

    // Request to the remainder unit.
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    // Status from the remainder unit.
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DATA_W-1:0] rem;
    } t_div_rsp;

endpackage

// ===== hw/rtl/xorshift64_ranged_random_top.sv =====
// Top level of the ranged xorshift random generator: control and output word.
//
//  channel   direction  handshake                  payload
//  request   in         i_in_valid / o_in_stall    i_range_low, i_range_high
//  result    out        o_out_valid / i_out_stall  o_random_value
//  seed      in         i_seed_we                  i_seed_value
//
// A request with range_low >= range_high goes from acceptance through S_PREP to
// S_FINISH, where the result word is loaded; the full 32-bit span also passes
// S_LOAD, and any other request also waits in S_DIV on the bit-serial remainder
// unit. Reset is synchronous and active low; it reloads the default seed. One
// request is in work at a time; a finished word waits in the output register
// while the next request is accepted and processed, and a stalled output only
// holds the block when a second result is ready.
`timescale 1ns / 1ps

module xorshift64_ranged_random_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_seed_we,
    input  logic [xrr_pkg::STATE_W-1:0] i_seed_value,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [xrr_pkg::DATA_W-1:0]  i_range_low,
    input  logic [xrr_pkg::DATA_W-1:0]  i_range_high,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [xrr_pkg::DATA_W-1:0]  o_random_value
);
    import xrr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_PREP   = 5'b00010,
        S_LOAD   = 5'b00100,
        S_DIV    = 5'b01000,
        S_FINISH = 5'b10000
    } t_fsm;

    t_fsm              r_fsm;
    t_fsm              n_fsm;
    logic [DATA_W-1:0] r_lo;
    logic [DATA_W-1:0] n_lo;
    logic [DATA_W-1:0] r_hi;
    logic [DATA_W-1:0] n_hi;
    logic              r_trivial;
    logic              n_trivial;
    logic [DATA_W-1:0] r_span;
    logic [DATA_W-1:0] n_span;
    logic [DATA_W-1:0] r_res;
    logic [DATA_W-1:0] n_res;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic [DATA_W-1:0] n_out_data;
    logic              w_accept;
    logic              w_advance;
    logic [DATA_W-1:0] w_raw;
    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;

    assign o_in_stall = (r_fsm != S_IDLE);
    assign w_accept   = i_in_valid && (r_fsm == S_IDLE);

    // Generator state.
    xrr_xorshift u_xorshift (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed_we    (i_seed_we),
        .i_seed_value (i_seed_value),
        .i_advance    (w_advance),
        .o_raw        (w_raw)
    );

    // Remainder of the raw word by the span.
    xrr_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Request sequencing and output word register.
    always_comb begin
        n_fsm       = r_fsm;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_trivial   = r_trivial;
        n_span      = r_span;
        n_res       = r_res;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && i_out_stall;
        w_advance   = 1'b0;
        w_div_req   = '{start: 1'b0, dividend: w_raw, divisor: r_span};
        case (r_fsm)
            S_IDLE: begin
                if (w_accept) begin
                    n_lo      = i_range_low;
                    n_hi      = i_range_high;
                    n_trivial = (i_range_low >= i_range_high);
                    n_fsm     = S_PREP;
                end
            end
            S_PREP: begin
                if (r_trivial) begin
                    n_res = r_lo;
                    n_fsm = S_FINISH;
                end else begin
                    w_advance = 1'b1;
                    n_span    = r_hi - r_lo + DATA_W'(1);
                    n_fsm     = S_LOAD;
                end
            end
            S_LOAD: begin
                // A span that wraps to zero covers every 32-bit value.
                if (r_span == '0) begin
                    n_res = r_lo + w_raw;
                    n_fsm = S_FINISH;
                end else begin
                    w_div_req.start = 1'b1;
                    n_fsm           = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_res = r_lo + w_div_rsp.rem;
                    n_fsm = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_fsm       = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm       <= n_fsm;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_trivial  <= n_trivial;
        r_span     <= n_span;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    assign o_out_valid    = r_out_valid;
    assign o_random_value = r_out_data;

    // The remainder unit only runs while a request waits on it.
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.busy |-> (r_fsm == S_DIV))
        else $error("remainder unit busy outside the divide state");

    // A finished remainder is always smaller than the span.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (w_div_rsp.rem < r_span))
        else $error("remainder not below span");

    // The generator only advances for a range that holds more than one value.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |-> (r_lo < r_hi))
        else $error("generator advanced for an empty range");

    // Nontrivial results stay inside the requested range.
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_FINISH) && !r_trivial && (r_span != '0)
            |-> (r_res >= r_lo) && (r_res <= r_hi))
        else $error("result outside the requested range");

endmodule

// ===== hw/rtl/xrr_xorshift.sv =====
// Generator state register with seed load and one xorshift step per advance.
`timescale 1ns / 1ps

module xrr_xorshift (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_seed_we,
    input  logic [xrr_pkg::STATE_W-1:0] i_seed_value,
    input  logic                        i_advance,
    output logic [xrr_pkg::DATA_W-1:0]  o_raw
);
    import xrr_pkg::*;

    logic [STATE_W-1:0] r_state;
    logic [STATE_W-1:0] n_state;
    logic [STATE_W-1:0] w_s1;
    logic [STATE_W-1:0] w_s2;
    logic [STATE_W-1:0] w_s3;

    // One xorshift step: three XOR-with-shift levels.
    always_comb begin
        w_s1 = r_state ^ (r_state << SHIFT_A);
        w_s2 = w_s1 ^ (w_s1 >> SHIFT_B);
        w_s3 = w_s2 ^ (w_s2 << SHIFT_C);
    end

    // A seed write wins; a zero seed falls back to the default.
    always_comb begin
        n_state = r_state;
        if (i_seed_we) begin
            n_state = (i_seed_value != '0) ? i_seed_value : SEED_DEFAULT;
        end else if (i_advance) begin
            n_state = w_s3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEED_DEFAULT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_raw = r_state[DATA_W-1:0];

endmodule

// ===== hw/rtl/xrr_divider.sv =====
// Restoring remainder unit that retires one dividend bit per cycle.
`timescale 1ns / 1ps

module xrr_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xrr_pkg::t_div_req i_req,
    output xrr_pkg::t_div_rsp o_rsp
);
    import xrr_pkg::*;

    localparam int unsigned CNT_W = $clog2(DATA_W + 1);

    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] n_rem;
    logic [DATA_W-1:0] r_dvd;
    logic [DATA_W-1:0] n_dvd;
    logic [DATA_W-1:0] r_div;
    logic [DATA_W-1:0] n_div;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic              r_done;
    logic              n_done;
    logic [DATA_W:0]   w_trial;
    logic [DATA_W:0]   w_diff;
    logic              w_busy;

    assign w_busy  = (r_cnt != '0);
    // Partial remainder with the next dividend bit shifted in.
    assign w_trial = {r_rem, r_dvd[DATA_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};

    // Bit-serial step: subtract when the trial value reaches the divisor.
    always_comb begin
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem = '0;
            n_dvd = i_req.dividend;
            n_div = i_req.divisor;
            n_cnt = CNT_W'(DATA_W);
        end else if (w_busy) begin
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = w_diff[DATA_W-1:0];
            end else begin
                n_rem = w_trial[DATA_W-1:0];
            end
            n_dvd  = {r_dvd[DATA_W-2:0], 1'b0};
            n_cnt  = r_cnt - CNT_W'(1);
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    // Datapath shift registers.
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_div <= n_div;
    end

    assign o_rsp.busy = w_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule
